/* sv/uarx_pkg.sv */
// Shared types and constants for the timestamped-edge UART receiver.
package uarx_pkg;

    localparam int TIME_W      = 32;
    localparam int BP_W        = 20;
    localparam int CFG_IDX_W   = 1;
    localparam int KIND_W      = 2;
    localparam int BYTE_W      = 8;
    localparam int N_SAMPLES   = 9;    // eight data bits plus the stop bit
    localparam int MAX_RESULTS = 32;
    localparam int QUEUE_DEPTH = 2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_BIT_PERIOD = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RX_ENABLE  = 1'd1;

    // command codes
    localparam logic CMD_CAPTURE = 1'b0;
    localparam logic CMD_SERVICE = 1'b1;

    // result kinds
    localparam logic [KIND_W-1:0] KIND_DATA     = 2'd0;
    localparam logic [KIND_W-1:0] KIND_FRAMING  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_OVERFLOW = 2'd2;

    typedef struct packed {
        logic              cmd;
        logic [TIME_W-1:0] time_stamp;
        logic              line_level;
    } item_t;

    typedef struct packed {
        logic              level;
        logic [TIME_W-1:0] stamp;
    } edge_word_t;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [BYTE_W-1:0] data;
    } result_t;

    typedef struct packed {
        logic  push;
        item_t word;
    } q_push_t;

endpackage

/* sv/uart_rx_edge_timestamp_decoder_top.sv */
// Top level of the timestamped-edge 8N1 UART receiver.
//
// Receives words of two kinds: a capture (cmd 0) stores one line edge (time and level) in
// a ring of EDGE_DEPTH entries; a service (cmd 1) carries the current time and decodes
// every complete frame in the ring, emitting up to 32 results (byte, framing error, or a
// single ring overflow), the last one flagged with last_of_run. Words pass through an
// input register and a two-entry queue, so the input keeps flowing while the engine works
// and while results wait on out_stall, until the queue and the input register are full.
// A service skips each high edge with one ring read, and for each decoded frame generates
// the nine sample times serially, then reads the ring edges after the start edge one at a
// time up to the first edge past the stop sample; a result may also wait on out_stall.
// While receiver_enable is 0 words are taken and dropped. A bit_period_cycles of 0 acts
// as 1.
module uart_rx_edge_timestamp_decoder_top
#(
    parameter int EDGE_DEPTH = 64
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [uarx_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [uarx_pkg::BP_W-1:0]       cfg_data,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic                            cmd,
    input  logic [uarx_pkg::TIME_W-1:0]     time_stamp,
    input  logic                            line_level,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [uarx_pkg::KIND_W-1:0]     result_kind,
    output logic [uarx_pkg::BYTE_W-1:0]     data_byte,
    output logic                            last_of_run
);

    logic [uarx_pkg::BP_W-1:0] bit_period_reg;
    logic                      rx_enable_reg;
    logic [uarx_pkg::BP_W-1:0] bit_period_eff;
    uarx_pkg::q_push_t         q_push;
    logic                      q_full;
    logic                      q_pop;
    logic                      q_valid;
    uarx_pkg::item_t           q_word;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bit_period_reg <= uarx_pkg::BP_W'(1);
            rx_enable_reg  <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                uarx_pkg::REG_BIT_PERIOD: bit_period_reg <= cfg_data;
                uarx_pkg::REG_RX_ENABLE:  rx_enable_reg  <= cfg_data[0];
                default: ;
            endcase
        end
    end

    assign bit_period_eff = (bit_period_reg == '0) ? uarx_pkg::BP_W'(1) : bit_period_reg;

    uarx_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .rx_enable  (rx_enable_reg),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .cmd        (cmd),
        .time_stamp (time_stamp),
        .line_level (line_level),
        .q_full     (q_full),
        .q_push     (q_push)
    );

    uarx_queue u_queue
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .q_push (q_push),
        .full   (q_full),
        .pop    (q_pop),
        .valid  (q_valid),
        .word   (q_word)
    );

    uarx_back
    #(
        .EDGE_DEPTH (EDGE_DEPTH)
    )
    u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .bit_period  (bit_period_eff),
        .q_valid     (q_valid),
        .q_word      (q_word),
        .q_pop       (q_pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .result_kind (result_kind),
        .data_byte   (data_byte),
        .last_of_run (last_of_run)
    );

endmodule

/* sv/uarx_front.sv */
// Front end: input word register, drops words while disabled, feeds the queue.
module uarx_front
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        rx_enable,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic                        cmd,
    input  logic [uarx_pkg::TIME_W-1:0] time_stamp,
    input  logic                        line_level,
    input  logic                        q_full,
    output uarx_pkg::q_push_t           q_push
);

    logic            valid_reg;
    logic            valid_next;
    uarx_pkg::item_t word_reg;
    logic            accept;

    assign in_stall = valid_reg && q_full;
    assign accept   = in_valid && !in_stall;

    assign q_push.push = valid_reg && !q_full;
    assign q_push.word = word_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (q_push.push)
        begin
            valid_next = 1'b0;
        end
        if (accept)
        begin
            // disabled receiver: word is taken and discarded
            valid_next = rx_enable;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            word_reg.cmd        <= cmd;
            word_reg.time_stamp <= time_stamp;
            word_reg.line_level <= line_level;
        end
    end

endmodule

/* sv/uarx_queue.sv */
// Small FIFO between the front end and the ring engine.
module uarx_queue
(
    input  logic              clk,
    input  logic              rst_n,
    input  uarx_pkg::q_push_t q_push,
    output logic              full,
    input  logic              pop,
    output logic              valid,
    output uarx_pkg::item_t   word
);

    localparam int DEPTH = uarx_pkg::QUEUE_DEPTH;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    uarx_pkg::item_t  slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_push;
    logic             do_pop;

    function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(p + 1'b1);
    endfunction

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign valid   = (count_reg != '0);
    assign word    = slot_reg[rd_ptr_reg];
    assign do_push = q_push.push && !full;
    assign do_pop  = pop && valid;

    always_comb
    begin
        wr_ptr_next = do_push ? bump(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = do_pop ? bump(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = CNT_W'(count_reg + 1'b1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = CNT_W'(count_reg - 1'b1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= q_push.word;
        end
    end

endmodule

/* sv/uarx_back.sv */
// Ring engine: edge ring memory, service walk, sampling and result output.
module uarx_back
#(
    parameter int EDGE_DEPTH = 64
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [uarx_pkg::BP_W-1:0]     bit_period,
    input  logic                          q_valid,
    input  uarx_pkg::item_t               q_word,
    output logic                          q_pop,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [uarx_pkg::KIND_W-1:0]   result_kind,
    output logic [uarx_pkg::BYTE_W-1:0]   data_byte,
    output logic                          last_of_run
);

    localparam int IDX_W  = $clog2(EDGE_DEPTH);
    localparam int CNT_W  = IDX_W + 1;
    localparam int N_W    = $clog2(uarx_pkg::MAX_RESULTS + 1);
    localparam int NS     = uarx_pkg::N_SAMPLES;
    localparam int TW     = uarx_pkg::TIME_W;
    localparam int BP10_W = uarx_pkg::BP_W + 4;

    localparam logic [3:0] ST_IDLE    = 4'd0;
    localparam logic [3:0] ST_SVC     = 4'd1;
    localparam logic [3:0] ST_CHECK   = 4'd2;
    localparam logic [3:0] ST_HEAD_RD = 4'd3;
    localparam logic [3:0] ST_TIMES   = 4'd4;
    localparam logic [3:0] ST_SCAN    = 4'd5;
    localparam logic [3:0] ST_SCAN_RD = 4'd6;
    localparam logic [3:0] ST_EMIT    = 4'd7;
    localparam logic [3:0] ST_FINISH  = 4'd8;

    uarx_pkg::edge_word_t ring_mem [EDGE_DEPTH];
    uarx_pkg::edge_word_t rd_data_reg;

    logic [3:0]       state_reg, state_next;
    logic [IDX_W-1:0] widx_reg, widx_next;
    logic [IDX_W-1:0] ridx_reg, ridx_next;
    logic [IDX_W-1:0] head_reg, head_next;
    logic [IDX_W-1:0] scan_reg, scan_next;
    logic [IDX_W-1:0] stop_reg, stop_next;
    logic             pend_reg, pend_next;
    logic [N_W-1:0]   n_reg, n_next;
    logic [2:0]       shift_cnt_reg, shift_cnt_next;
    logic [NS-1:0]    done_reg, done_next;
    logic [NS-1:0]    lvl_reg, lvl_next;
    logic [TW-1:0]    when_reg [NS];
    logic [TW-1:0]    when_next [NS];
    logic [TW-1:0]    now_reg, now_next;
    logic             hold_valid_reg, hold_valid_next;
    uarx_pkg::result_t hold_reg, hold_next;
    logic             out_valid_reg, out_valid_next;
    uarx_pkg::result_t out_reg, out_next;
    logic             out_last_reg, out_last_next;

    logic             mem_we;
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic             out_free;
    logic [IDX_W-1:0] widx_inc;
    logic [CNT_W-1:0] fill;
    logic [TW-1:0]    bp_ext;
    logic [TW-1:0]    bp10;
    logic [TW-1:0]    age;

    function automatic logic [IDX_W-1:0] nxt(input logic [IDX_W-1:0] i);
        return (i == IDX_W'(EDGE_DEPTH - 1)) ? '0 : IDX_W'(i + 1'b1);
    endfunction

    // t strictly after s, modulo 2^32 with the sign of the difference
    function automatic logic later(input logic [TW-1:0] t, input logic [TW-1:0] s);
        logic [TW-1:0] d;
        d = t - s;
        return (d != '0) && !d[TW-1];
    endfunction

    assign out_free    = !out_valid_reg || !out_stall;
    assign out_valid   = out_valid_reg;
    assign result_kind = out_reg.kind;
    assign data_byte   = out_reg.data;
    assign last_of_run = out_last_reg;

    assign widx_inc = nxt(widx_reg);
    assign fill     = (widx_inc >= ridx_reg)
                      ? CNT_W'({1'b0, widx_inc} - {1'b0, ridx_reg})
                      : CNT_W'({1'b0, widx_inc} + CNT_W'(EDGE_DEPTH) - {1'b0, ridx_reg});
    assign bp_ext   = TW'(bit_period);
    assign bp10     = TW'(BP10_W'({bit_period, 3'b000}) + BP10_W'({bit_period, 1'b0}));
    assign age      = now_reg - rd_data_reg.stamp;

    always_comb
    begin
        state_next      = state_reg;
        widx_next       = widx_reg;
        ridx_next       = ridx_reg;
        head_next       = head_reg;
        scan_next       = scan_reg;
        stop_next       = stop_reg;
        pend_next       = pend_reg;
        n_next          = n_reg;
        shift_cnt_next  = shift_cnt_reg;
        done_next       = done_reg;
        lvl_next        = lvl_reg;
        when_next       = when_reg;
        now_next        = now_reg;
        hold_valid_next = hold_valid_reg;
        hold_next       = hold_reg;
        out_valid_next  = out_valid_reg && out_stall;
        out_next        = out_reg;
        out_last_next   = out_last_reg;
        q_pop           = 1'b0;
        mem_we          = 1'b0;
        rd_en           = 1'b0;
        rd_addr         = ridx_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop = 1'b1;
                    if (q_word.cmd == uarx_pkg::CMD_CAPTURE)
                    begin
                        mem_we    = 1'b1;
                        widx_next = widx_inc;
                        if (fill >= CNT_W'(EDGE_DEPTH - 2))
                        begin
                            pend_next = 1'b1;
                        end
                    end
                    else
                    begin
                        now_next   = q_word.time_stamp;
                        head_next  = widx_reg;
                        n_next     = '0;
                        state_next = ST_SVC;
                    end
                end
            end
            ST_SVC:
            begin
                if (pend_reg)
                begin
                    pend_next       = 1'b0;
                    ridx_next       = head_reg;
                    hold_valid_next = 1'b1;
                    hold_next.kind  = uarx_pkg::KIND_OVERFLOW;
                    hold_next.data  = '0;
                    state_next      = ST_FINISH;
                end
                else
                begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (ridx_reg == head_reg || n_reg == N_W'(uarx_pkg::MAX_RESULTS))
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    rd_en      = 1'b1;
                    rd_addr    = ridx_reg;
                    state_next = ST_HEAD_RD;
                end
            end
            ST_HEAD_RD:
            begin
                if (rd_data_reg.level)
                begin
                    ridx_next  = nxt(ridx_reg);
                    state_next = ST_CHECK;
                end
                else if (age < bp10)
                begin
                    // start edge too young: frame not complete yet
                    state_next = ST_FINISH;
                end
                else
                begin
                    when_next[NS-1] = rd_data_reg.stamp + bp_ext + (bp_ext >> 1);
                    shift_cnt_next  = '0;
                    done_next       = '0;
                    lvl_next        = '0;
                    scan_next       = nxt(ridx_reg);
                    stop_next       = head_reg;
                    state_next      = ST_TIMES;
                end
            end
            ST_TIMES:
            begin
                // shift sample times down, top slot steps by one bit period
                for (int k = 0; k < NS - 1; k++)
                begin
                    when_next[k] = when_reg[k+1];
                end
                when_next[NS-1] = when_reg[NS-1] + bp_ext;
                shift_cnt_next  = 3'(shift_cnt_reg + 1'b1);
                if (shift_cnt_reg == 3'(NS - 2))
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (scan_reg == head_reg || (&done_reg))
                begin
                    state_next = ST_EMIT;
                end
                else
                begin
                    rd_en      = 1'b1;
                    rd_addr    = scan_reg;
                    state_next = ST_SCAN_RD;
                end
            end
            ST_SCAN_RD:
            begin
                for (int b = 0; b < NS; b++)
                begin
                    if (!done_reg[b])
                    begin
                        if (later(rd_data_reg.stamp, when_reg[b]))
                        begin
                            done_next[b] = 1'b1;
                        end
                        else
                        begin
                            lvl_next[b] = rd_data_reg.level;
                        end
                    end
                end
                if (!done_reg[NS-1] && later(rd_data_reg.stamp, when_reg[NS-1]))
                begin
                    stop_next = scan_reg;
                end
                scan_next  = nxt(scan_reg);
                state_next = ST_SCAN;
            end
            ST_EMIT:
            begin
                if (!hold_valid_reg || out_free)
                begin
                    if (hold_valid_reg)
                    begin
                        out_valid_next = 1'b1;
                        out_next       = hold_reg;
                        out_last_next  = 1'b0;
                    end
                    hold_valid_next = 1'b1;
                    n_next          = N_W'(n_reg + 1'b1);
                    if (!lvl_reg[NS-1])
                    begin
                        hold_next.kind = uarx_pkg::KIND_FRAMING;
                        hold_next.data = '0;
                        ridx_next      = nxt(ridx_reg);
                    end
                    else
                    begin
                        hold_next.kind = uarx_pkg::KIND_DATA;
                        hold_next.data = lvl_reg[uarx_pkg::BYTE_W-1:0];
                        ridx_next      = stop_reg;
                    end
                    state_next = ST_CHECK;
                end
            end
            ST_FINISH:
            begin
                if (!hold_valid_reg)
                begin
                    state_next = ST_IDLE;
                end
                else if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_next        = hold_reg;
                    out_last_next   = 1'b1;
                    hold_valid_next = 1'b0;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            widx_reg       <= '0;
            ridx_reg       <= '0;
            pend_reg       <= 1'b0;
            hold_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            n_reg          <= '0;
            shift_cnt_reg  <= '0;
            done_reg       <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            widx_reg       <= widx_next;
            ridx_reg       <= ridx_next;
            pend_reg       <= pend_next;
            hold_valid_reg <= hold_valid_next;
            out_valid_reg  <= out_valid_next;
            n_reg          <= n_next;
            shift_cnt_reg  <= shift_cnt_next;
            done_reg       <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        head_reg     <= head_next;
        scan_reg     <= scan_next;
        stop_reg     <= stop_next;
        lvl_reg      <= lvl_next;
        when_reg     <= when_next;
        now_reg      <= now_next;
        hold_reg     <= hold_next;
        out_reg      <= out_next;
        out_last_reg <= out_last_next;
    end

    // edge ring: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            ring_mem[widx_reg] <= '{level: q_word.line_level, stamp: q_word.time_stamp};
        end
        if (rd_en)
        begin
            rd_data_reg <= ring_mem[rd_addr];
        end
    end

endmodule

/* tb/uart_rx_edge_timestamp_decoder_top_test.sv */
`timescale 1ns / 100ps
// Self-checking testbench for the timestamped-edge UART receiver top level.
module uart_rx_edge_timestamp_decoder_top_test;

    localparam int     TIME_W        = uarx_pkg::TIME_W;
    localparam int     BP_W          = uarx_pkg::BP_W;
    localparam int     CFG_IDX_W     = uarx_pkg::CFG_IDX_W;
    localparam int     KIND_W        = uarx_pkg::KIND_W;
    localparam int     BYTE_W        = uarx_pkg::BYTE_W;
    localparam int     MAX_RESULTS   = uarx_pkg::MAX_RESULTS;
    localparam int     EDGE_DEPTH    = 64;
    localparam int     PTR_W         = $clog2(EDGE_DEPTH);
    localparam int     RANDOM_WORDS  = 100;
    localparam int     PHASE_WORDS   = 25;
    localparam int     SETTLE_CYCLES = 600;
    localparam longint CYCLE_LIMIT   = 3_000_000;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [BYTE_W-1:0] data;
        logic              last;
    } rx_result_t;

    logic                 clk        = 1'b0;
    logic                 rst_n      = 1'b0;
    logic                 cfg_we     = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index  = '0;
    logic [BP_W-1:0]      cfg_data   = '0;
    logic                 in_valid   = 1'b0;
    logic                 in_stall;
    logic                 cmd        = uarx_pkg::CMD_CAPTURE;
    logic [TIME_W-1:0]    time_stamp = '0;
    logic                 line_level = 1'b0;
    logic                 out_valid;
    logic                 out_stall  = 1'b0;
    logic [KIND_W-1:0]    result_kind;
    logic [BYTE_W-1:0]    data_byte;
    logic                 last_of_run;

    // receiver model state
    logic [TIME_W-1:0] edge_stamp_mem [EDGE_DEPTH];
    logic              edge_level_mem [EDGE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr;
    logic [PTR_W-1:0]  rd_ptr;
    logic              drop_pending;
    logic [BP_W-1:0]   period_reg;
    logic              rx_on;
    rx_result_t        expected_results [$];

    bit     tx_idle = 1'b1;
    bit     rx_idle = 1'b1;
    int     rx_wait = 0;
    int     words_sent = 0;
    int     results_seen = 0;
    int     mismatches = 0;
    longint cycle_count = 0;

    uart_rx_edge_timestamp_decoder_top #(.EDGE_DEPTH(EDGE_DEPTH)) u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .cmd         (cmd),
        .time_stamp  (time_stamp),
        .line_level  (line_level),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .result_kind (result_kind),
        .data_byte   (data_byte),
        .last_of_run (last_of_run)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // t strictly after s, wrapping signed compare
    function automatic logic time_after(input logic [TIME_W-1:0] t,
                                        input logic [TIME_W-1:0] s);
        logic [TIME_W-1:0] d;
        d = t - s;
        return (d != '0) && !d[TIME_W-1];
    endfunction

    // pointers wrap naturally since the depth is a power of two
    function automatic logic sampled_level(input logic [PTR_W-1:0] first,
                                           input logic [PTR_W-1:0] head,
                                           input logic [TIME_W-1:0] when);
        logic             lvl;
        logic [PTR_W-1:0] e;
        lvl = edge_level_mem[first];
        e = first + 1'b1;
        while (e != head && !time_after(edge_stamp_mem[e], when))
        begin
            lvl = edge_level_mem[e];
            e = e + 1'b1;
        end
        return lvl;
    endfunction

    function automatic logic [PTR_W-1:0] next_edge_after(input logic [PTR_W-1:0] first,
                                                         input logic [PTR_W-1:0] head,
                                                         input logic [TIME_W-1:0] when);
        logic [PTR_W-1:0] e;
        e = first + 1'b1;
        while (e != head && !time_after(edge_stamp_mem[e], when))
            e = e + 1'b1;
        return e;
    endfunction

    function automatic logic [TIME_W-1:0] cur_bp();
        return (period_reg == '0) ? TIME_W'(1) : TIME_W'(period_reg);
    endfunction

    // Update the model with one accepted word and queue the results it decodes.
    function automatic void decode_word(input logic w_cmd, input logic [TIME_W-1:0] w_stamp,
                                        input logic w_level);
        logic [TIME_W-1:0] bp;
        logic [TIME_W-1:0] start;
        logic [TIME_W-1:0] stop_at;
        logic [PTR_W-1:0]  head;
        logic [PTR_W-1:0]  fill;
        logic [BYTE_W-1:0] value;
        rx_result_t        run [$];
        if (!rx_on)
            return;
        bp = cur_bp();
        if (w_cmd == uarx_pkg::CMD_CAPTURE)
        begin
            edge_stamp_mem[wr_ptr] = w_stamp;
            edge_level_mem[wr_ptr] = w_level;
            wr_ptr = wr_ptr + 1'b1;
            fill = wr_ptr - rd_ptr;
            if (fill >= EDGE_DEPTH - 2)
                drop_pending = 1'b1;
            return;
        end
        head = wr_ptr;
        if (drop_pending)
        begin
            drop_pending = 1'b0;
            rd_ptr = head;
            expected_results.push_back('{uarx_pkg::KIND_OVERFLOW, '0, 1'b1});
            return;
        end
        while (rd_ptr != head && run.size() < MAX_RESULTS)
        begin
            if (edge_level_mem[rd_ptr])
            begin
                rd_ptr = rd_ptr + 1'b1;
                continue;
            end
            start = edge_stamp_mem[rd_ptr];
            if (w_stamp - start < bp * TIME_W'(10))
                break;
            value = '0;
            for (int b = 0; b < 8; b++)
                value[b] = sampled_level(rd_ptr, head, start + bp + bp / 2 + bp * TIME_W'(b));
            stop_at = start + bp * TIME_W'(9) + bp / 2;
            if (!sampled_level(rd_ptr, head, stop_at))
            begin
                run.push_back('{uarx_pkg::KIND_FRAMING, '0, 1'b0});
                rd_ptr = rd_ptr + 1'b1;
                continue;
            end
            run.push_back('{uarx_pkg::KIND_DATA, value, 1'b0});
            rd_ptr = next_edge_after(rd_ptr, head, stop_at);
        end
        if (run.size() > 0)
            run[run.size() - 1].last = 1'b1;
        foreach (run[i])
            expected_results.push_back(run[i]);
    endfunction

    // result side: check each accepted result, then stall for a random count while rx_idle is set
    always @(posedge clk)
    begin : rx_check
        rx_result_t exp_r;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                results_seen++;
                if (expected_results.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: unexpected result kind %0d byte %02h last %0d",
                             $time, result_kind, data_byte, last_of_run);
                end
                else
                begin
                    exp_r = expected_results.pop_front();
                    if (result_kind !== exp_r.kind || data_byte !== exp_r.data ||
                        last_of_run !== exp_r.last)
                    begin
                        mismatches++;
                        $display("%0t: mismatch, expected kind/byte/last %0d/%02h/%0d, got %0d/%02h/%0d",
                                 $time, exp_r.kind, exp_r.data, exp_r.last,
                                 result_kind, data_byte, last_of_run);
                    end
                end
                rx_wait = rx_idle ? $urandom_range(0, 14) : 0;
                out_stall <= (rx_wait != 0);
            end
            else if (rx_wait != 0)
            begin
                rx_wait--;
                out_stall <= (rx_wait != 0);
            end
        end
    end

    task automatic send_word(input logic w_cmd, input logic [TIME_W-1:0] w_stamp,
                             input logic w_level);
        int gap;
        gap = tx_idle ? $urandom_range(0, 14) : 0;
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        cmd        <= w_cmd;
        time_stamp <= w_stamp;
        line_level <= w_level;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        if (rx_on)
            words_sent++;
        decode_word(w_cmd, w_stamp, w_level);
    endtask

    // lowers valid, waits for every result, then lets the engine go quiet
    task automatic drain();
        in_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [BP_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == uarx_pkg::REG_BIT_PERIOD)
            period_reg = value;
        else if (idx == uarx_pkg::REG_RX_ENABLE)
            rx_on = value[0];
        @(posedge clk);
    endtask

    // 8N1 frame as line edges: start low, one edge per level change, back high at the end
    task automatic send_frame(input logic [TIME_W-1:0] t0, input logic [BYTE_W-1:0] value,
                              input logic stop_ok, output logic [TIME_W-1:0] t_end);
        logic [TIME_W-1:0] bp;
        logic              prev;
        logic              lvl;
        bp = cur_bp();
        send_word(uarx_pkg::CMD_CAPTURE, t0, 1'b0);
        prev = 1'b0;
        for (int k = 1; k <= 9; k++)
        begin
            lvl = (k == 9) ? stop_ok : value[k - 1];
            if (lvl != prev)
                send_word(uarx_pkg::CMD_CAPTURE, t0 + bp * TIME_W'(k), lvl);
            prev = lvl;
        end
        if (!prev)
            send_word(uarx_pkg::CMD_CAPTURE, t0 + bp * TIME_W'(10), 1'b1);
        t_end = t0 + bp * TIME_W'(11);
    endtask

    task automatic test_disabled();
        logic [TIME_W-1:0] t_end;
        write_reg(uarx_pkg::REG_RX_ENABLE, '0);
        send_frame(32'h0000_1000, 8'h3C, 1'b1, t_end);
        send_word(uarx_pkg::CMD_SERVICE, t_end, 1'b1);
        drain();
        write_reg(uarx_pkg::REG_RX_ENABLE, 20'd1);
    endtask

    task automatic test_byte_frames();
        logic [TIME_W-1:0] t;
        drain();
        write_reg(uarx_pkg::REG_BIT_PERIOD, 20'd8);
        t = '0;
        send_frame(t, 8'h00, 1'b1, t);
        send_frame(t, 8'hFF, 1'b1, t);
        send_frame(t, 8'hA5, 1'b1, t);
        send_word(uarx_pkg::CMD_SERVICE, t, 1'b0);
        // start edge at the all-ones time, frame wraps through zero
        send_frame(32'hFFFF_FFFF, 8'h81, 1'b1, t);
        send_word(uarx_pkg::CMD_SERVICE, t, 1'b1);
        // empty ring: nothing to report
        send_word(uarx_pkg::CMD_SERVICE, t + 32'd500, 1'b0);
    endtask

    task automatic test_framing_error();
        logic [TIME_W-1:0] t0;
        logic [TIME_W-1:0] t_end;
        drain();
        write_reg(uarx_pkg::REG_BIT_PERIOD, 20'd16);
        t0 = 32'h7FFF_FF80;
        send_frame(t0, 8'h12, 1'b0, t_end);
        // start edge still too young
        send_word(uarx_pkg::CMD_SERVICE, t0 + 32'd80, 1'b0);
        send_word(uarx_pkg::CMD_SERVICE, t_end, 1'b0);
        send_frame(t_end + 32'd40, 8'h00, 1'b0, t_end);
        send_word(uarx_pkg::CMD_SERVICE, t_end, 1'b1);
    endtask

    task automatic test_zero_period();
        logic [TIME_W-1:0] t;
        drain();
        write_reg(uarx_pkg::REG_BIT_PERIOD, '0);
        t = $urandom;
        send_frame(t, 8'h96, 1'b1, t);
        send_word(uarx_pkg::CMD_SERVICE, t, 1'b0);
        drain();
        write_reg(uarx_pkg::REG_BIT_PERIOD, 20'd1);
        send_frame(t, 8'h3C, 1'b1, t);
        send_frame(t, 8'hE7, 1'b0, t);
        send_word(uarx_pkg::CMD_SERVICE, t, 1'b0);
    endtask

    // more framing errors than one service may return
    task automatic test_result_cap();
        logic [TIME_W-1:0] t0;
        drain();
        write_reg(uarx_pkg::REG_BIT_PERIOD, 20'd4);
        t0 = 32'h0012_3400;
        for (int i = 0; i < 36; i++)
            send_word(uarx_pkg::CMD_CAPTURE, t0 + TIME_W'(i * 48), 1'b0);
        send_word(uarx_pkg::CMD_CAPTURE, t0 + TIME_W'(36 * 48), 1'b1);
        send_word(uarx_pkg::CMD_SERVICE, t0 + TIME_W'(40 * 48), 1'b0);
        send_word(uarx_pkg::CMD_SERVICE, t0 + TIME_W'(41 * 48), 1'b1);
    endtask

    task automatic test_ring_overflow();
        logic [TIME_W-1:0] t;
        drain();
        write_reg(uarx_pkg::REG_BIT_PERIOD, 20'd5);
        t = 32'hC000_0000;
        for (int i = 0; i < EDGE_DEPTH; i++)
            send_word(uarx_pkg::CMD_CAPTURE, t + TIME_W'(i * 5), i[0]);
        send_word(uarx_pkg::CMD_SERVICE, t + 32'd2000, 1'b0);
        send_word(uarx_pkg::CMD_SERVICE, t + 32'd2100, 1'b0);
        send_frame(t + 32'd3000, 8'h5A, 1'b1, t);
        send_word(uarx_pkg::CMD_SERVICE, t, 1'b1);
    endtask

    task automatic test_max_period();
        logic [TIME_W-1:0] t0;
        logic [TIME_W-1:0] t_end;
        drain();
        write_reg(uarx_pkg::REG_BIT_PERIOD, 20'hFFFFF);
        t0 = 32'h7FF8_0000;
        send_frame(t0, 8'hC3, 1'b1, t_end);
        send_word(uarx_pkg::CMD_SERVICE, t0 + 32'd10485749, 1'b0);
        send_word(uarx_pkg::CMD_SERVICE, t_end, 1'b1);
    endtask

    task automatic random_burst(inout logic [TIME_W-1:0] cursor);
        logic [TIME_W-1:0] bp;
        logic [TIME_W-1:0] t_end;
        int                pick;
        bp = cur_bp();
        pick = $urandom_range(0, 9);
        if (pick == 0)
            send_word(uarx_pkg::CMD_CAPTURE,
                      $urandom_range(0, 1) ? $urandom : cursor + $urandom_range(0, 5) * bp,
                      1'($urandom));
        else if (pick == 1)
            send_word(uarx_pkg::CMD_SERVICE, $urandom_range(0, 1) ? $urandom : cursor,
                      1'($urandom));
        else
        begin
            repeat ($urandom_range(1, 4))
            begin
                send_frame(cursor, 8'($urandom), $urandom_range(0, 7) != 0, t_end);
                if ($urandom_range(0, 5) == 0)
                    send_word(uarx_pkg::CMD_SERVICE, cursor + bp * $urandom_range(0, 9),
                              1'($urandom));
                cursor = t_end + bp * $urandom_range(0, 3);
            end
            send_word(uarx_pkg::CMD_SERVICE, cursor + $urandom_range(0, bp), 1'($urandom));
        end
    endtask

    task automatic test_random_traffic();
        logic [TIME_W-1:0] cursor;
        int                base;
        int                phase_base;
        int                phase;
        base = words_sent;
        phase = 0;
        while (words_sent - base < RANDOM_WORDS)
        begin
            drain();
            unique case (phase % 4)
                0:       write_reg(uarx_pkg::REG_BIT_PERIOD, 20'($urandom_range(2, 40)));
                1:       write_reg(uarx_pkg::REG_BIT_PERIOD, 20'd1);
                2:       write_reg(uarx_pkg::REG_BIT_PERIOD, 20'($urandom_range(41, 4000)));
                default: write_reg(uarx_pkg::REG_BIT_PERIOD, 20'hFFFFF);
            endcase
            cursor = $urandom;
            phase_base = words_sent;
            while (words_sent - phase_base < PHASE_WORDS && words_sent - base < RANDOM_WORDS)
            begin
                if ($urandom_range(0, 3) == 0)
                begin
                    tx_idle = $urandom_range(0, 2) != 0;
                    rx_idle = $urandom_range(0, 2) != 0;
                end
                random_burst(cursor);
                if ($urandom_range(0, 9) == 0)
                    drain();
            end
            phase++;
        end
        tx_idle = 1'b1;
        rx_idle = 1'b1;
    endtask

    task automatic test_disable_again();
        drain();
        write_reg(uarx_pkg::REG_RX_ENABLE, '0);
        repeat (6)
            send_word(1'($urandom), $urandom, 1'($urandom));
    endtask

    initial
    begin
        foreach (edge_stamp_mem[i])
        begin
            edge_stamp_mem[i] = '0;
            edge_level_mem[i] = 1'b0;
        end
        wr_ptr       = '0;
        rd_ptr       = '0;
        drop_pending = 1'b0;
        period_reg   = 20'd1;
        rx_on        = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_disabled();
        test_byte_frames();
        test_framing_error();
        test_zero_period();
        test_result_cap();
        test_ring_overflow();
        test_max_period();
        test_random_traffic();
        test_disable_again();
        drain();
        $display("Sent %0d words with the receiver on, checked %0d results;", words_sent,
                 results_seen);
        $display("bit periods 0, 1 and max, framing, result cap, overflow and time wrap covered.");
        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

/* sim.f */
sv/uarx_pkg.sv
sv/uarx_front.sv
sv/uarx_queue.sv
sv/uarx_back.sv
sv/uart_rx_edge_timestamp_decoder_top.sv
tb/uart_rx_edge_timestamp_decoder_top_test.sv
